// File: src/road_strip_quad_tessellator_core_defines.svh
// ----------------------------------------------------------------------------
// Road strip quad tessellator - assertion macros
// Concurrent assertion helpers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ROAD_STRIP_QUAD_TESSELLATOR_CORE_DEFINES_SVH
`define ROAD_STRIP_QUAD_TESSELLATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RSQT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rsqt assertion failed");
`define RSQT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("rsqt forbidden condition seen");
`else
`define RSQT_ASSERT(lbl, clk, rst_n, prop)
`define RSQT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// File: src/rsqt_pkg.sv
// ----------------------------------------------------------------------------
// rsqt_pkg
// Widths, reset values and register codes of the road strip tessellator.
// ----------------------------------------------------------------------------
package rsqt_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned MagW   = 24;
  localparam int unsigned RegW   = 16;
  localparam int unsigned LenW   = 25;
  localparam int unsigned RadW   = 49;
  localparam int unsigned SqSteps = 25;
  localparam int unsigned ProdW  = MagW + LenW;
  localparam int unsigned NumW   = 50;
  localparam int unsigned DenW   = LenW;
  localparam int unsigned PtW    = 27;
  localparam int unsigned TexW   = 24;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned MaxSegmentsDef = 32;

  localparam logic [RegW-1:0] HalfWidthRst = 16'd896;
  localparam logic [RegW-1:0] ClearanceRst = 16'd896;
  localparam logic [RegW-1:0] MaxPieceRst  = 16'd1280;

  typedef enum logic [1:0] {
    RegHalfWidth = 2'd0,
    RegClearance = 2'd1,
    RegMaxPiece  = 2'd2
  } reg_idx_e;

  function automatic logic [CoordW-1:0] sat_coord(input logic signed [PtW-1:0] v);
    logic [CoordW-1:0] r;
    if (&v[PtW-1:CoordW-1] || ~|v[PtW-1:CoordW-1]) begin
      r = v[CoordW-1:0];
    end else if (v[PtW-1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: src/rsqt_div.sv
// ----------------------------------------------------------------------------
// rsqt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsqt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsqt_pkg::NumW-1:0]  num_i,
  input  logic [rsqt_pkg::DenW-1:0]  den_i,
  output logic                       done_o,
  output logic [rsqt_pkg::NumW-1:0]  quot_o,
  output logic [rsqt_pkg::DenW-1:0]  rem_o
);
  import rsqt_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(NumW);

  logic [NumW-1:0] acc_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [DenW:0]   sh, diff;
  logic            ge;

  assign sh   = {rem_q, acc_q[NumW-1]};
  assign diff = sh - {1'b0, den_q};
  assign ge   = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        acc_q <= num_i;
        den_q <= den_i;
        rem_q <= '0;
        cnt_q <= Steps;
        run_q <= 1'b1;
      end else if (run_q) begin
        acc_q <= {acc_q[NumW-2:0], ge};
        rem_q <= ge ? diff[DenW-1:0] : sh[DenW-1:0];
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

endmodule

// File: src/rsqt_sqrt.sv
// ----------------------------------------------------------------------------
// rsqt_sqrt
// Digit-by-digit square root, one result bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module rsqt_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsqt_pkg::RadW-1:0]  rad_i,
  output logic                       done_o,
  output logic [rsqt_pkg::LenW-1:0]  root_o
);
  import rsqt_pkg::*;

  localparam int unsigned KW = $clog2(SqSteps);

  logic [RadW-1:0] n_q;
  logic [RadW:0]   r_q;
  logic [KW-1:0]   k_q;
  logic            run_q, done_q;
  logic [RadW:0]   bit_w, t_w, rnd_w;
  logic            take;

  assign bit_w = (RadW+1)'(1) << {k_q, 1'b0};
  assign t_w   = r_q + bit_w;
  assign take  = {1'b0, n_q} >= t_w;
  assign rnd_w = ({1'b0, n_q} > r_q) ? r_q + (RadW+1)'(1) : r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      r_q    <= '0;
      k_q    <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        n_q   <= rad_i;
        r_q   <= '0;
        k_q   <= KW'(SqSteps - 1);
        run_q <= 1'b1;
      end else if (run_q) begin
        if (take) begin
          n_q <= n_q - t_w[RadW-1:0];
          r_q <= (r_q >> 1) + bit_w;
        end else begin
          r_q <= r_q >> 1;
        end
        k_q <= k_q - KW'(1);
        if (k_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = rnd_w[LenW-1:0];

endmodule

// File: src/road_strip_quad_tessellator_core.sv
// ----------------------------------------------------------------------------
// road_strip_quad_tessellator_core
// Cuts one road edge into intersection/road/intersection quads, or one quad.
// ----------------------------------------------------------------------------
// Usage: write half_width (0x0), clearance (0x4) and max_piece_length (0x8)
// over the APB port while the core is idle; all reset to 3.5, 3.5 and 5.0 m.
// An edge beat is taken on a clock edge with start high and busy low. The
// core then stays busy for the whole edge: a bit-serial square root, two
// offset divisions and, when the middle is split, a piece-count division;
// then two point divisions for the start point and for each quad, plus a
// texture division for each road quad when half_width is nonzero. A
// zero-length edge needs only the square root. An edge shorter than two
// clearances, or of zero length, gives a single intersection quad.
// Busy drops while the last beat is on the ports, so the next edge can be
// taken in that cycle; one edge is worked on at a time.
// Each quad appears for one cycle with result_valid_o high; last_quad_o
// marks the final one. The receiver cannot stall the core and must take
// every beat. Reset returns the core to idle and restores register defaults.
module road_strip_quad_tessellator_core #(
  parameter int unsigned MAX_SEGMENTS = rsqt_pkg::MaxSegmentsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rsqt_pkg::AddrW-1:0]        paddr,
  input  logic [rsqt_pkg::DataW-1:0]        pwdata,
  output logic [rsqt_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rsqt_pkg::CoordW-1:0] start_x_i,
  input  logic signed [rsqt_pkg::CoordW-1:0] start_y_i,
  input  logic signed [rsqt_pkg::CoordW-1:0] end_x_i,
  input  logic signed [rsqt_pkg::CoordW-1:0] end_y_i,
  output logic                              result_valid_o,
  output logic                              quad_kind_o,
  output logic signed [rsqt_pkg::CoordW-1:0] corner0_x_o,
  output logic signed [rsqt_pkg::CoordW-1:0] corner0_y_o,
  output logic signed [rsqt_pkg::CoordW-1:0] corner1_x_o,
  output logic signed [rsqt_pkg::CoordW-1:0] corner1_y_o,
  output logic signed [rsqt_pkg::CoordW-1:0] corner2_x_o,
  output logic signed [rsqt_pkg::CoordW-1:0] corner2_y_o,
  output logic signed [rsqt_pkg::CoordW-1:0] corner3_x_o,
  output logic signed [rsqt_pkg::CoordW-1:0] corner3_y_o,
  output logic [rsqt_pkg::TexW-1:0]         tex_v_start_o,
  output logic [rsqt_pkg::TexW-1:0]         tex_v_end_o,
  output logic                              last_quad_o
);
  import rsqt_pkg::*;

  `include "road_strip_quad_tessellator_core_defines.svh"

  localparam int unsigned PcW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_SQRT_W,
    S_OFFX_M, S_OFFX_D, S_OFFX_W, S_OFFY_M, S_OFFY_D, S_OFFY_W,
    S_PLAN, S_CNT_W,
    S_PTX_M, S_PTX_D, S_PTX_W, S_PTY_M, S_PTY_D, S_PTY_W,
    S_TEX, S_TEX_W, S_EMIT
  } state_e;

  // configuration
  logic [RegW-1:0] hw_q, clr_q, mpl_q;
  reg_idx_e        cfg_idx;
  logic            cfg_wr;

  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q  <= HalfWidthRst;
      clr_q <= ClearanceRst;
      mpl_q <= MaxPieceRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegHalfWidth: hw_q  <= pwdata[RegW-1:0];
        RegClearance: clr_q <= pwdata[RegW-1:0];
        RegMaxPiece:  mpl_q <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegHalfWidth: prdata = DataW'(hw_q);
      RegClearance: prdata = DataW'(clr_q);
      RegMaxPiece:  prdata = DataW'(mpl_q);
      default:      prdata = '0;
    endcase
  end

  // datapath registers
  state_e                  state_q;
  logic signed [CoordW-1:0] sx_q, sy_q;
  logic [MagW-1:0]         adx_q, ady_q;
  logic                    dxn_q, dyn_q;
  logic [ProdW-1:0]        acc_q, prod_q;
  logic [LenW-1:0]         len_q, s_q, moved_q, rem_q;
  logic [RegW-1:0]         piece_q;
  logic [PcW-1:0]          pieces_q;
  logic                    short_q, first_q, kind_q, last_q;
  logic signed [PtW-1:0]   offx_q, offy_q, pax_q, pay_q, pbx_q, pby_q;
  logic [TexW-1:0]         texa_q, texb_q;
  logic                    valid_q;

  // shared multiplier
  logic [MagW-1:0]  mul_a;
  logic [LenW-1:0]  mul_b;
  logic [ProdW-1:0] prod_d;

  always_comb begin
    case (state_q)
      S_SQX:    begin mul_a = adx_q; mul_b = LenW'(adx_q); end
      S_SQY:    begin mul_a = ady_q; mul_b = LenW'(ady_q); end
      S_OFFX_M: begin mul_a = ady_q; mul_b = LenW'(hw_q);  end
      S_OFFY_M: begin mul_a = adx_q; mul_b = LenW'(hw_q);  end
      S_PTY_M:  begin mul_a = ady_q; mul_b = s_q;          end
      default:  begin mul_a = adx_q; mul_b = s_q;          end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // shared divider and root
  logic            div_start, div_done, sq_start, sq_done;
  logic [NumW-1:0] div_num, div_quot;
  logic [DenW-1:0] div_den, div_rem;
  logic [LenW-1:0] sq_root;

  rsqt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  rsqt_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (RadW'(acc_q) + RadW'(prod_q)),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // plan of the middle
  logic [LenW-1:0] c2_w, mid_w, twop_w;
  logic [RegW-1:0] piece_w;
  logic            short_w, split_w;

  assign c2_w    = LenW'({clr_q, 1'b0});
  assign short_w = len_q < c2_w;
  assign mid_w   = len_q - c2_w;
  assign piece_w = (mpl_q == '0) ? RegW'(1) : mpl_q;
  assign twop_w  = LenW'({piece_w, 1'b0});
  assign split_w = mid_w > twop_w;

  always_comb begin
    div_start = 1'b0;
    div_num   = NumW'(prod_q) + NumW'(len_q >> 1);
    div_den   = len_q;
    sq_start  = (state_q == S_SQRT);
    case (state_q)
      S_OFFX_D, S_OFFY_D, S_PTX_D, S_PTY_D: div_start = 1'b1;
      S_PLAN: begin
        div_start = !short_w && split_w;
        div_num   = NumW'(mid_w);
        div_den   = DenW'(piece_w);
      end
      S_TEX: begin
        div_start = !first_q && kind_q && (hw_q != '0);
        div_num   = NumW'({moved_q, 7'b0}) + NumW'(hw_q >> 1);
        div_den   = DenW'(hw_q);
      end
      default: ;
    endcase
  end

  // quotient to signed point offset
  logic signed [PtW-1:0] qv_w, ptx_w, pty_w;
  logic [TexW-1:0]       tex_w;
  logic [PcW-1:0]        cnt_w;

  assign qv_w  = $signed({1'b0, div_quot[PtW-2:0]});
  assign ptx_w = PtW'(sx_q) + (dxn_q ? -qv_w : qv_w);
  assign pty_w = PtW'(sy_q) + (dyn_q ? -qv_w : qv_w);
  assign tex_w = (|div_quot[NumW-1:TexW]) ? '1 : div_quot[TexW-1:0];

  always_comb begin
    if (div_quot >= NumW'(MAX_SEGMENTS)) begin
      cnt_w = PcW'(MAX_SEGMENTS);
    end else begin
      cnt_w = PcW'(div_quot) + PcW'(div_rem != '0);
    end
  end

  // next boundary along the edge
  logic [LenW-1:0] step_w, s_d, moved_d, rem_d;
  logic [PcW-1:0]  pieces_d;
  logic            kind_d, last_d;

  always_comb begin
    if (pieces_q == PcW'(1)) begin
      step_w = rem_q;
    end else begin
      step_w = (LenW'(piece_q) < rem_q) ? LenW'(piece_q) : rem_q;
    end
    s_d      = s_q + step_w;
    moved_d  = moved_q + step_w;
    rem_d    = rem_q - step_w;
    pieces_d = pieces_q - PcW'(1);
    kind_d   = 1'b1;
    last_d   = 1'b0;
    if (first_q) begin
      s_d      = short_q ? len_q : LenW'(clr_q);
      moved_d  = '0;
      rem_d    = rem_q;
      pieces_d = pieces_q;
      kind_d   = 1'b0;
      last_d   = short_q;
    end else if (kind_q && (pieces_q == '0)) begin
      s_d      = len_q;
      moved_d  = moved_q;
      rem_d    = rem_q;
      pieces_d = pieces_q;
      kind_d   = 1'b0;
      last_d   = 1'b1;
    end
  end

  // sequencer
  logic [CoordW-1:0] c0x_q, c0y_q, c1x_q, c1y_q, c2x_q, c2y_q, c3x_q, c3y_q;
  logic [TexW-1:0]   tvs_q, tve_q;
  logic              okind_q, olast_q;
  logic signed [DiffW-1:0] dx_w, dy_w;

  assign dx_w = DiffW'(end_x_i) - DiffW'(start_x_i);
  assign dy_w = DiffW'(end_y_i) - DiffW'(start_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sx_q     <= '0;
      sy_q     <= '0;
      adx_q    <= '0;
      ady_q    <= '0;
      dxn_q    <= 1'b0;
      dyn_q    <= 1'b0;
      acc_q    <= '0;
      len_q    <= '0;
      s_q      <= '0;
      moved_q  <= '0;
      rem_q    <= '0;
      piece_q  <= '0;
      pieces_q <= '0;
      short_q  <= 1'b0;
      first_q  <= 1'b0;
      kind_q   <= 1'b0;
      last_q   <= 1'b0;
      offx_q   <= '0;
      offy_q   <= '0;
      pax_q    <= '0;
      pay_q    <= '0;
      pbx_q    <= '0;
      pby_q    <= '0;
      texa_q   <= '0;
      texb_q   <= '0;
      valid_q  <= 1'b0;
      okind_q  <= 1'b0;
      olast_q  <= 1'b0;
      tvs_q    <= '0;
      tve_q    <= '0;
      c0x_q <= '0; c0y_q <= '0; c1x_q <= '0; c1y_q <= '0;
      c2x_q <= '0; c2y_q <= '0; c3x_q <= '0; c3y_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            sx_q    <= start_x_i;
            sy_q    <= start_y_i;
            dxn_q   <= dx_w[DiffW-1];
            dyn_q   <= dy_w[DiffW-1];
            adx_q   <= MagW'(dx_w[DiffW-1] ? -dx_w : dx_w);
            ady_q   <= MagW'(dy_w[DiffW-1] ? -dy_w : dy_w);
            state_q <= S_SQX;
          end
        end
        S_SQX: state_q <= S_SQY;
        S_SQY: begin
          acc_q   <= prod_q;
          state_q <= S_SQRT;
        end
        S_SQRT: state_q <= S_SQRT_W;
        S_SQRT_W: begin
          if (sq_done) begin
            len_q <= sq_root;
            if (sq_root == '0) begin
              pax_q   <= PtW'(sx_q);
              pay_q   <= PtW'(sy_q);
              pbx_q   <= PtW'(sx_q);
              pby_q   <= PtW'(sy_q);
              offx_q  <= '0;
              offy_q  <= '0;
              texa_q  <= '0;
              texb_q  <= '0;
              kind_q  <= 1'b0;
              last_q  <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_OFFX_M;
            end
          end
        end
        S_OFFX_M: state_q <= S_OFFX_D;
        S_OFFX_D: state_q <= S_OFFX_W;
        S_OFFX_W: begin
          if (div_done) begin
            offx_q  <= dyn_q ? -qv_w : qv_w;
            state_q <= S_OFFY_M;
          end
        end
        S_OFFY_M: state_q <= S_OFFY_D;
        S_OFFY_D: state_q <= S_OFFY_W;
        S_OFFY_W: begin
          if (div_done) begin
            offy_q  <= dxn_q ? qv_w : -qv_w;
            state_q <= S_PLAN;
          end
        end
        S_PLAN: begin
          short_q  <= short_w;
          rem_q    <= mid_w;
          piece_q  <= piece_w;
          pieces_q <= PcW'(1);
          s_q      <= '0;
          moved_q  <= '0;
          first_q  <= 1'b1;
          state_q  <= (!short_w && split_w) ? S_CNT_W : S_PTX_M;
        end
        S_CNT_W: begin
          if (div_done) begin
            pieces_q <= cnt_w;
            state_q  <= S_PTX_M;
          end
        end
        S_PTX_M: state_q <= S_PTX_D;
        S_PTX_D: state_q <= S_PTX_W;
        S_PTX_W: begin
          if (div_done) begin
            pbx_q   <= ptx_w;
            state_q <= S_PTY_M;
          end
        end
        S_PTY_M: state_q <= S_PTY_D;
        S_PTY_D: state_q <= S_PTY_W;
        S_PTY_W: begin
          if (div_done) begin
            pby_q   <= pty_w;
            state_q <= S_TEX;
          end
        end
        S_TEX: begin
          if (first_q) begin
            pax_q    <= pbx_q;
            pay_q    <= pby_q;
            texa_q   <= '0;
            first_q  <= 1'b0;
            s_q      <= s_d;
            moved_q  <= moved_d;
            rem_q    <= rem_d;
            pieces_q <= pieces_d;
            kind_q   <= kind_d;
            last_q   <= last_d;
            state_q  <= S_PTX_M;
          end else if (kind_q && (hw_q != '0)) begin
            state_q <= S_TEX_W;
          end else begin
            texb_q  <= '0;
            state_q <= S_EMIT;
          end
        end
        S_TEX_W: begin
          if (div_done) begin
            texb_q  <= tex_w;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          valid_q <= 1'b1;
          okind_q <= kind_q;
          olast_q <= last_q;
          tvs_q   <= kind_q ? texa_q : '0;
          tve_q   <= kind_q ? texb_q : '0;
          c0x_q <= sat_coord(pax_q + offx_q);
          c0y_q <= sat_coord(pay_q + offy_q);
          c1x_q <= sat_coord(pbx_q + offx_q);
          c1y_q <= sat_coord(pby_q + offy_q);
          c2x_q <= sat_coord(pbx_q - offx_q);
          c2y_q <= sat_coord(pby_q - offy_q);
          c3x_q <= sat_coord(pax_q - offx_q);
          c3y_q <= sat_coord(pay_q - offy_q);
          if (last_q) begin
            state_q <= S_IDLE;
          end else begin
            pax_q    <= pbx_q;
            pay_q    <= pby_q;
            texa_q   <= texb_q;
            s_q      <= s_d;
            moved_q  <= moved_d;
            rem_q    <= rem_d;
            pieces_q <= pieces_d;
            kind_q   <= kind_d;
            last_q   <= last_d;
            state_q  <= S_PTX_M;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign quad_kind_o    = okind_q;
  assign last_quad_o    = olast_q;
  assign tex_v_start_o  = tvs_q;
  assign tex_v_end_o    = tve_q;
  assign corner0_x_o    = c0x_q;
  assign corner0_y_o    = c0y_q;
  assign corner1_x_o    = c1x_q;
  assign corner1_y_o    = c1y_q;
  assign corner2_x_o    = c2x_q;
  assign corner2_y_o    = c2y_q;
  assign corner3_x_o    = c3x_q;
  assign corner3_y_o    = c3y_q;

  `RSQT_ASSERT(a_beat_follows_busy, clk_i, rst_ni, result_valid_o |-> $past(busy))
  `RSQT_ASSERT(a_start_goes_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `RSQT_NEVER(a_beat_after_last, clk_i, rst_ni,
              $past(result_valid_o && last_quad_o) && result_valid_o)

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Road strip quad tessellator testbench
// Sends road edges to the core under several register settings. Each edge
// accepted by the core is turned into its expected quads by a software
// model. Every quad the core emits is checked, field by field, against the
// oldest expected quad.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsqt_pkg::*;

  localparam int QuietLimit = 20000;

  typedef struct {
    logic              kind;
    logic [CoordW-1:0] crn [8];
    logic [TexW-1:0]   tv0;
    logic [TexW-1:0]   tv1;
    logic              last;
  } quad_t;

  class quad_board;
    quad_t  pending[$];
    longint hw = 896, clr = 896, pce = 1280;
    int     fails = 0;

    function longint rnd_div(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
    endfunction

    function logic [CoordW-1:0] clip(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[CoordW-1:0];
    endfunction

    function longint tex(longint moved);
      longint v;
      if (hw == 0) return 0;
      v = (moved * 128 + hw / 2) / hw;
      return (v > 24'hFFFFFF) ? 24'hFFFFFF : v;
    endfunction

    function void push_quad(longint sx, longint sy, longint dx, longint dy, longint len,
                            longint ox, longint oy, logic kind, longint s, longint e,
                            longint vs, longint ve, logic last);
      quad_t  q;
      longint ax, ay, bx, by;
      ax = sx + (len != 0 ? rnd_div(dx * s, len) : 0);
      ay = sy + (len != 0 ? rnd_div(dy * s, len) : 0);
      bx = sx + (len != 0 ? rnd_div(dx * e, len) : 0);
      by = sy + (len != 0 ? rnd_div(dy * e, len) : 0);
      q.kind   = kind;
      q.crn[0] = clip(ax + ox);
      q.crn[1] = clip(ay + oy);
      q.crn[2] = clip(bx + ox);
      q.crn[3] = clip(by + oy);
      q.crn[4] = clip(bx - ox);
      q.crn[5] = clip(by - oy);
      q.crn[6] = clip(ax - ox);
      q.crn[7] = clip(ay - oy);
      q.tv0    = vs[TexW-1:0];
      q.tv1    = ve[TexW-1:0];
      q.last   = last;
      pending = {pending, q};
    endfunction

    function void note_edge(logic signed [CoordW-1:0] sxi, logic signed [CoordW-1:0] syi,
                            logic signed [CoordW-1:0] exi, logic signed [CoordW-1:0] eyi);
      longint sx, sy, dx, dy, ox, oy, len, nrm, bit_v, mid, piece, n, s, moved, rem, l;
      sx = sxi;
      sy = syi;
      dx = longint'(exi) - sx;
      dy = longint'(eyi) - sy;
      nrm = dx * dx + dy * dy;
      len = 0;
      bit_v = longint'(1) << 62;
      while (bit_v > nrm) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
        if (nrm >= len + bit_v) begin
          nrm = nrm - (len + bit_v);
          len = (len >> 1) + bit_v;
        end else begin
          len = len >> 1;
        end
        bit_v = bit_v >> 2;
      end
      if (nrm > len) len++;
      if (len == 0) begin
        push_quad(sx, sy, dx, dy, 0, 0, 0, 1'b0, 0, 0, 0, 0, 1'b1);
        return;
      end
      ox = rnd_div(dy * hw, len);
      oy = rnd_div(-dx * hw, len);
      if (len < 2 * clr) begin
        push_quad(sx, sy, dx, dy, len, ox, oy, 1'b0, 0, len, 0, 0, 1'b1);
        return;
      end
      push_quad(sx, sy, dx, dy, len, ox, oy, 1'b0, 0, clr, 0, 0, 1'b0);
      mid = len - 2 * clr;
      piece = (pce != 0) ? pce : 1;
      if (mid > 2 * piece) begin
        n = (mid + piece - 1) / piece;
        if (n > MaxSegmentsDef) n = MaxSegmentsDef;
        s = clr;
        moved = 0;
        rem = mid;
        for (longint k = 0; k < n; k++) begin
          l = (k == n - 1) ? rem : ((piece < rem) ? piece : rem);
          push_quad(sx, sy, dx, dy, len, ox, oy, 1'b1, s, s + l, tex(moved),
                    tex(moved + l), 1'b0);
          s += l;
          moved += l;
          rem -= l;
        end
      end else begin
        push_quad(sx, sy, dx, dy, len, ox, oy, 1'b1, clr, clr + mid, 0, tex(mid), 1'b0);
      end
      push_quad(sx, sy, dx, dy, len, ox, oy, 1'b0, len - clr, len, 0, 0, 1'b1);
    endfunction

    function void check_quad(quad_t got);
      quad_t exp_q;
      if (pending.size() == 0) begin
        $display("%0t: unexpected quad beat", $realtime);
        fails++;
        return;
      end
      exp_q = pending.pop_front();
      if (got.kind !== exp_q.kind) begin
        $display("%0t: quad_kind exp %0d got %0d", $realtime, exp_q.kind, got.kind);
        fails++;
      end
      for (int i = 0; i < 8; i++)
        if (got.crn[i] !== exp_q.crn[i]) begin
          $display("%0t: corner%0d_%s exp %h got %h", $realtime, i / 2,
                   (i % 2) ? "y" : "x", exp_q.crn[i], got.crn[i]);
          fails++;
        end
      if (got.tv0 !== exp_q.tv0) begin
        $display("%0t: tex_v_start exp %h got %h", $realtime, exp_q.tv0, got.tv0);
        fails++;
      end
      if (got.tv1 !== exp_q.tv1) begin
        $display("%0t: tex_v_end exp %h got %h", $realtime, exp_q.tv1, got.tv1);
        fails++;
      end
      if (got.last !== exp_q.last) begin
        $display("%0t: last_quad exp %0d got %0d", $realtime, exp_q.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic signed [CoordW-1:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic result_valid_o, quad_kind_o, last_quad_o;
  logic signed [CoordW-1:0] corner0_x_o, corner0_y_o, corner1_x_o, corner1_y_o;
  logic signed [CoordW-1:0] corner2_x_o, corner2_y_o, corner3_x_o, corner3_y_o;
  logic [TexW-1:0] tex_v_start_o, tex_v_end_o;

  quad_board board = new();
  int quiet = 0;
  bit no_gaps = 1'b0;

  road_strip_quad_tessellator_core u_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    quad_t got;
    if (rst_ni && result_valid_o) begin
      got.kind   = quad_kind_o;
      got.crn[0] = corner0_x_o;
      got.crn[1] = corner0_y_o;
      got.crn[2] = corner1_x_o;
      got.crn[3] = corner1_y_o;
      got.crn[4] = corner2_x_o;
      got.crn[5] = corner2_y_o;
      got.crn[6] = corner3_x_o;
      got.crn[7] = corner3_y_o;
      got.tv0    = tex_v_start_o;
      got.tv1    = tex_v_end_o;
      got.last   = last_quad_o;
      board.check_quad(got);
    end
    if (!rst_ni || result_valid_o || (start && !busy)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("[road_strip_quad_tessellator_core] ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (board.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [RegW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_road(logic [RegW-1:0] hw, logic [RegW-1:0] cl, logic [RegW-1:0] pc);
    start <= 1'b0;
    drain();
    reg_write(RegHalfWidth, hw);
    reg_write(RegClearance, cl);
    reg_write(RegMaxPiece, pc);
    board.hw  = hw;
    board.clr = cl;
    board.pce = pc;
  endtask

  task automatic send_edge(longint sx, longint sy, longint ex, longint ey);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    start_x_i <= sx[CoordW-1:0];
    start_y_i <= sy[CoordW-1:0];
    end_x_i   <= ex[CoordW-1:0];
    end_y_i   <= ey[CoordW-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_edge(sx[CoordW-1:0], sy[CoordW-1:0], ex[CoordW-1:0], ey[CoordW-1:0]);
  endtask

  function automatic longint pin(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic random_edge();
    longint sx, sy, ex, ey, span;
    int mode;
    mode = $urandom_range(0, 99);
    sx = longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
    sy = longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
    if (mode >= 85 && mode < 95) begin
      sx = $urandom_range(0, 1) ? 8388607 - longint'($urandom_range(0, 3000))
                                : -8388608 + longint'($urandom_range(0, 3000));
      sy = $urandom_range(0, 1) ? 8388607 - longint'($urandom_range(0, 3000))
                                : -8388608 + longint'($urandom_range(0, 3000));
    end
    if (mode < 8) begin
      ex = sx;
      ey = sy;
    end else if (mode >= 95) begin
      ex = longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
      ey = longint'($signed($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
    end else begin
      span = (mode < 58) ? 3000 : 20000;
      ex = pin(sx + longint'($urandom_range(0, 2 * span)) - span);
      ey = pin(sy + longint'($urandom_range(0, 2 * span)) - span);
    end
    send_edge(sx, sy, ex, ey);
  endtask

  initial begin
    logic [RegW-1:0] hw, cl, pc;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_edge(0, 0, 0, 0);
    send_edge(8388607, -8388608, 8388607, -8388608);
    send_edge(100, 200, 900, 200);
    send_edge(0, 0, 1792, 0);
    send_edge(0, 0, 0, -4352);
    send_edge(-5000, 0, -5000 + 4353, 0);
    send_edge(0, 0, 3000, 4000);
    send_edge(-8388608, -8388608, 8388607, 8388607);
    send_edge(8388607, 0, -8388608, 0);
    send_edge(8388607, 8388607, 8388607 - 10000, 8388607);
    send_edge(-8388608, -8388608, -8388608, -8388608 + 9000);
    send_edge(1234, -5678, -20000, 15000);
    for (int i = 0; i < 24; i++) begin
      if (i % 8 == 0) no_gaps = ~no_gaps;
      random_edge();
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin hw = 16'd0;     cl = 16'd896;   pc = 16'd1280;  end
        1: begin hw = 16'd65535; cl = 16'd896;   pc = 16'd1280;  end
        2: begin hw = 16'd1;     cl = 16'd0;     pc = 16'd0;     end
        3: begin hw = 16'd896;   cl = 16'd65535; pc = 16'd1;     end
        4: begin hw = 16'd300;   cl = 16'd100;   pc = 16'd65535; end
        5: begin hw = 16'd896;   cl = 16'd0;     pc = 16'd200;   end
        default: begin
          hw = RegW'($urandom_range(0, 65535));
          cl = RegW'($urandom_range(0, 3000));
          pc = RegW'($urandom_range(300, 65535));
        end
      endcase
      set_road(hw, cl, pc);
      if (ph == 2) send_edge(0, 0, 20000, 0);
      for (int i = 0; i < 43; i++) begin
        if (i % 11 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        random_edge();
      end
    end

    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("[road_strip_quad_tessellator_core] OK");
    end else begin
      $display("[road_strip_quad_tessellator_core] ERROR");
    end
    $finish;
  end

endmodule

// File: road_strip_quad_tessellator_core.f
+incdir+src
src/rsqt_pkg.sv
src/rsqt_div.sv
src/rsqt_sqrt.sv
src/road_strip_quad_tessellator_core.sv
bench/testbench.sv
